>>> rtl/mm3h_pkg.sv
// Shared types and constants for the MurmurHash3 x64 128-bit hash stream.
// Used by every module of the block. Has no dependencies.
package mm3h_pkg;

   localparam int LANE_W      = 64;
   localparam int HALF_W      = 32;
   localparam int LEN_W       = 32;
   localparam int SEED_W      = 32;
   localparam int COUNT_W     = 5;
   localparam int TAIL_W      = 4;
   localparam int WORD_BYTES  = 8;
   localparam int BLOCK_BYTES = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LANE_W-1:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
   localparam logic [LANE_W-1:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
   localparam logic [LANE_W-1:0] ADD_ONE = 64'h0000_0000_52dc_e729;
   localparam logic [LANE_W-1:0] ADD_TWO = 64'h0000_0000_3849_5ab5;
   localparam logic [LANE_W-1:0] FMIX_M1 = 64'hff51_afd7_ed55_8ccd;
   localparam logic [LANE_W-1:0] FMIX_M2 = 64'hc4ce_b9fe_1a85_ec53;

   typedef struct packed {
      logic [LANE_W-1:0] word_low;
      logic [LANE_W-1:0] word_high;
      logic [TAIL_W-1:0] tail_bytes;
      logic              full_block;
      logic              last_block;
   } item_type;

   typedef struct packed {
      logic idle;
      logic in_message;
   } back_status_type;

endpackage

>>> rtl/mm3h_front.sv
// Front end: takes request transfers, masks tail bytes and classifies each block.
// Depends on mm3h_pkg; feeds mm3h_queue.
module mm3h_front
   import mm3h_pkg::*;
(
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [LANE_W-1:0]  req_word_low,
   input  logic [LANE_W-1:0]  req_word_high,
   input  logic [COUNT_W-1:0] req_byte_count,
   input  logic               req_last_block,
   input  logic               q_full,
   output logic               q_push,
   output item_type           q_item
);

   logic full_block;

   assign full_block = !req_last_block || (req_byte_count >= COUNT_W'(BLOCK_BYTES));
   assign req_stall  = q_full;
   assign q_push     = req_valid && !q_full;

   always_comb begin
      q_item            = '0;
      q_item.full_block = full_block;
      q_item.last_block = req_last_block;
      q_item.tail_bytes = full_block ? '0 : req_byte_count[TAIL_W-1:0];
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (full_block || (COUNT_W'(i) < req_byte_count)) begin
            q_item.word_low[8*i +: 8] = req_word_low[8*i +: 8];
         end
         if (full_block || (COUNT_W'(i + WORD_BYTES) < req_byte_count)) begin
            q_item.word_high[8*i +: 8] = req_word_high[8*i +: 8];
         end
      end
   end

endmodule

>>> rtl/mm3h_queue.sv
// Short FIFO of classified blocks between the front end and the mixing engine.
// Depends on mm3h_pkg.
module mm3h_queue
   import mm3h_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  item_type               push_item,
   input  logic                   pop,
   output item_type               pop_item,
   output logic                   full,
   output logic                   not_empty,
   output logic [QUEUE_CNT_W-1:0] count
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/mm3h_mul.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Built from 32-bit partial products. Depends on mm3h_pkg.
module mm3h_mul
   import mm3h_pkg::*;
(
   input  logic              clock,
   input  logic [LANE_W-1:0] mul_a,
   input  logic [LANE_W-1:0] mul_b,
   output logic [LANE_W-1:0] product
);

   logic [LANE_W-1:0] part_low_ff;
   logic [LANE_W-1:0] part_low_in;
   logic [HALF_W-1:0] part_ab_ff;
   logic [HALF_W-1:0] part_ab_in;
   logic [HALF_W-1:0] part_ba_ff;
   logic [HALF_W-1:0] part_ba_in;
   logic [LANE_W-1:0] product_ff;
   logic [LANE_W-1:0] product_in;

   assign part_low_in = {{HALF_W{1'b0}}, mul_a[HALF_W-1:0]} *
                        {{HALF_W{1'b0}}, mul_b[HALF_W-1:0]};
   assign part_ab_in  = mul_a[HALF_W-1:0] * mul_b[LANE_W-1:HALF_W];
   assign part_ba_in  = mul_a[LANE_W-1:HALF_W] * mul_b[HALF_W-1:0];
   assign product_in  = part_low_ff + {part_ab_ff + part_ba_ff, {HALF_W{1'b0}}};
   assign product     = product_ff;

   always_ff @(posedge clock) begin
      part_low_ff <= part_low_in;
      part_ab_ff  <= part_ab_in;
      part_ba_ff  <= part_ba_in;
      product_ff  <= product_in;
   end

endmodule

>>> rtl/mm3h_back.sv
// Mixing engine: body and tail key mixing, lane updates, finalization and result register.
// Depends on mm3h_pkg; drives mm3h_mul and pops mm3h_queue.
module mm3h_back
   import mm3h_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SEED_W-1:0] seed,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic [LANE_W-1:0] mul_a,
   output logic [LANE_W-1:0] mul_b,
   input  logic [LANE_W-1:0] mul_product,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LANE_W-1:0] rsp_hash_first,
   output logic [LANE_W-1:0] rsp_hash_second,
   output back_status_type   status
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] ST_K_MUL1   = 4'd1;
   localparam logic [ST_W-1:0] ST_K_WAIT1  = 4'd2;
   localparam logic [ST_W-1:0] ST_K_MUL2   = 4'd3;
   localparam logic [ST_W-1:0] ST_K_WAIT2  = 4'd4;
   localparam logic [ST_W-1:0] ST_K_APPLY  = 4'd5;
   localparam logic [ST_W-1:0] ST_L_FIVE   = 4'd6;
   localparam logic [ST_W-1:0] ST_FIN_ADD1 = 4'd7;
   localparam logic [ST_W-1:0] ST_FIN_ADD2 = 4'd8;
   localparam logic [ST_W-1:0] ST_F_MUL1   = 4'd9;
   localparam logic [ST_W-1:0] ST_F_WAIT1  = 4'd10;
   localparam logic [ST_W-1:0] ST_F_MUL2   = 4'd11;
   localparam logic [ST_W-1:0] ST_F_WAIT2  = 4'd12;
   localparam logic [ST_W-1:0] ST_F_APPLY  = 4'd13;
   localparam logic [ST_W-1:0] ST_OUT_ADD1 = 4'd14;
   localparam logic [ST_W-1:0] ST_OUT_ADD2 = 4'd15;

   logic [ST_W-1:0]   state_ff;
   logic [ST_W-1:0]   state_in;
   logic              sel_ff;
   logic              sel_in;
   logic              in_msg_ff;
   logic              in_msg_in;
   item_type          cmd_ff;
   item_type          cmd_in;
   logic [LANE_W-1:0] lane_one_ff;
   logic [LANE_W-1:0] lane_one_in;
   logic [LANE_W-1:0] lane_two_ff;
   logic [LANE_W-1:0] lane_two_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [LANE_W-1:0] hash_first_ff;
   logic [LANE_W-1:0] hash_first_in;
   logic [LANE_W-1:0] hash_second_ff;
   logic [LANE_W-1:0] hash_second_in;

   logic [LANE_W-1:0] lane_sel;
   logic [LANE_W-1:0] lane_oth;
   logic [LANE_W-1:0] key_word;
   logic [LANE_W-1:0] mixed;
   logic [LANE_W-1:0] lane_new;
   logic [LANE_W-1:0] len_wide;

   assign lane_sel = sel_ff ? lane_two_ff : lane_one_ff;
   assign lane_oth = sel_ff ? lane_one_ff : lane_two_ff;
   assign key_word = sel_ff ? cmd_ff.word_high : cmd_ff.word_low;
   assign mixed    = lane_sel ^ mul_product;
   assign len_wide = {{(LANE_W-LEN_W){1'b0}}, len_ff};

   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      in_msg_in      = in_msg_ff;
      cmd_in         = cmd_ff;
      lane_one_in    = lane_one_ff;
      lane_two_in    = lane_two_ff;
      len_in         = len_ff;
      rsp_valid_in   = rsp_valid_ff;
      hash_first_in  = hash_first_ff;
      hash_second_in = hash_second_ff;
      lane_new       = lane_sel;
      q_pop          = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_item;
               sel_in   = 1'b0;
               state_in = ST_K_MUL1;
               if (!in_msg_ff) begin
                  lane_one_in = {{(LANE_W-SEED_W){1'b0}}, seed};
                  lane_two_in = {{(LANE_W-SEED_W){1'b0}}, seed};
                  len_in      = '0;
                  in_msg_in   = 1'b1;
               end
            end
         end
         ST_K_MUL1: begin
            mul_a    = key_word;
            mul_b    = sel_ff ? MIX_C2 : MIX_C1;
            state_in = ST_K_WAIT1;
         end
         ST_K_WAIT1: begin
            state_in = ST_K_MUL2;
         end
         ST_K_MUL2: begin
            mul_a    = sel_ff ? {mul_product[30:0], mul_product[63:31]}
                              : {mul_product[32:0], mul_product[63:33]};
            mul_b    = sel_ff ? MIX_C1 : MIX_C2;
            state_in = ST_K_WAIT2;
         end
         ST_K_WAIT2: begin
            state_in = ST_K_APPLY;
         end
         ST_K_APPLY: begin
            if (cmd_ff.full_block) begin
               lane_new = (sel_ff ? {mixed[32:0], mixed[63:33]}
                                  : {mixed[36:0], mixed[63:37]}) + lane_oth;
               state_in = ST_L_FIVE;
            end else begin
               lane_new = mixed;
               if (sel_ff) begin
                  len_in   = len_ff + {{(LEN_W-TAIL_W){1'b0}}, cmd_ff.tail_bytes};
                  state_in = ST_FIN_ADD1;
               end else begin
                  sel_in   = 1'b1;
                  state_in = ST_K_MUL1;
               end
            end
            if (sel_ff) begin
               lane_two_in = lane_new;
            end else begin
               lane_one_in = lane_new;
            end
         end
         ST_L_FIVE: begin
            lane_new = {lane_sel[LANE_W-3:0], 2'b00} + lane_sel + (sel_ff ? ADD_TWO : ADD_ONE);
            if (sel_ff) begin
               lane_two_in = lane_new;
               len_in      = len_ff + LEN_W'(BLOCK_BYTES);
               state_in    = cmd_ff.last_block ? ST_FIN_ADD1 : ST_IDLE;
            end else begin
               lane_one_in = lane_new;
               sel_in      = 1'b1;
               state_in    = ST_K_MUL1;
            end
         end
         ST_FIN_ADD1: begin
            lane_one_in = (lane_one_ff ^ len_wide) + (lane_two_ff ^ len_wide);
            lane_two_in = lane_two_ff ^ len_wide;
            state_in    = ST_FIN_ADD2;
         end
         ST_FIN_ADD2: begin
            lane_two_in = lane_two_ff + lane_one_ff;
            sel_in      = 1'b0;
            state_in    = ST_F_MUL1;
         end
         ST_F_MUL1: begin
            mul_a    = lane_sel ^ (lane_sel >> 33);
            mul_b    = FMIX_M1;
            state_in = ST_F_WAIT1;
         end
         ST_F_WAIT1: begin
            state_in = ST_F_MUL2;
         end
         ST_F_MUL2: begin
            mul_a    = mul_product ^ (mul_product >> 33);
            mul_b    = FMIX_M2;
            state_in = ST_F_WAIT2;
         end
         ST_F_WAIT2: begin
            state_in = ST_F_APPLY;
         end
         ST_F_APPLY: begin
            lane_new = mul_product ^ (mul_product >> 33);
            if (sel_ff) begin
               lane_two_in = lane_new;
               state_in    = ST_OUT_ADD1;
            end else begin
               lane_one_in = lane_new;
               sel_in      = 1'b1;
               state_in    = ST_F_MUL1;
            end
         end
         ST_OUT_ADD1: begin
            lane_one_in = lane_one_ff + lane_two_ff;
            state_in    = ST_OUT_ADD2;
         end
         ST_OUT_ADD2: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               hash_first_in  = lane_one_ff;
               hash_second_in = lane_two_ff + lane_one_ff;
               rsp_valid_in   = 1'b1;
               in_msg_in      = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      sel_ff         <= sel_in;
      lane_one_ff    <= lane_one_in;
      lane_two_ff    <= lane_two_in;
      len_ff         <= len_in;
      hash_first_ff  <= hash_first_in;
      hash_second_ff <= hash_second_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hash_first    = hash_first_ff;
   assign rsp_hash_second   = hash_second_ff;
   assign status.idle       = (state_ff == ST_IDLE);
   assign status.in_message = in_msg_ff;

endmodule

>>> rtl/murmur3_x64_128_hash_stream.sv
// MurmurHash3 x64 128-bit streaming hash, top level.
// Blocks reach the mixing engine through the block queue. It mixes the key of each
// block, updates the lanes for a full block, and for a last block then finalizes.
// It mixes one block at a time, on the single shared two-stage 64-bit multiplier.
// Reset (synchronous): clears the seed, queue, result valid and message state.
module murmur3_x64_128_hash_stream
   import mm3h_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [LANE_W-1:0]  req_word_low,
   input  logic [LANE_W-1:0]  req_word_high,
   input  logic [COUNT_W-1:0] req_byte_count,
   input  logic               req_last_block,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [LANE_W-1:0]  rsp_hash_first,
   output logic [LANE_W-1:0]  rsp_hash_second,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SEED_W-1:0]  csr_hash_seed
);

   logic [SEED_W-1:0]      hash_seed_ff;
   logic [SEED_W-1:0]      hash_seed_in;
   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_valid;
   item_type               q_push_item;
   item_type               q_pop_item;
   logic [QUEUE_CNT_W-1:0] q_count;
   logic [LANE_W-1:0]      mul_a;
   logic [LANE_W-1:0]      mul_b;
   logic [LANE_W-1:0]      mul_product;
   back_status_type        status;

   assign csr_ready    = 1'b1;
   assign hash_seed_in = (csr_valid && csr_ready) ? csr_hash_seed : hash_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= '0;
      end else begin
         hash_seed_ff <= hash_seed_in;
      end
   end

   mm3h_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word_low   (req_word_low),
      .req_word_high  (req_word_high),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_push_item)
   );

   mm3h_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .full      (q_full),
      .not_empty (q_valid),
      .count     (q_count)
   );

   mm3h_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_product)
   );

   mm3h_back u_back (
      .clock           (clock),
      .reset           (reset),
      .seed            (hash_seed_ff),
      .q_valid         (q_valid),
      .q_item          (q_pop_item),
      .q_pop           (q_pop),
      .mul_a           (mul_a),
      .mul_b           (mul_b),
      .mul_product     (mul_product),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_first  (rsp_hash_first),
      .rsp_hash_second (rsp_hash_second),
      .status          (status)
   );

   assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("block queue over capacity");

   assert property (@(posedge clock) disable iff (reset)
      status.idle && q_valid |=> !status.idle)
      else $error("engine idle with a queued block");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !status.in_message)
      else $error("result issued while message still open");

endmodule
